// ----- rtl/bc1_pkg.sv -----
package bc1_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] RegRowPitch = 2'd0;
  localparam logic [1:0] RegOriginX  = 2'd1;
  localparam logic [1:0] RegOriginY  = 2'd2;

  // x/3 as (x*171)>>9, exact for x below 512
  localparam int unsigned DivThreeMul   = 171;
  localparam int unsigned DivThreeShift = 9;

  localparam logic [7:0] AlphaOpaque = 8'hFF;

  typedef struct packed {
    logic [63:0] block_word;
    logic [13:0] block_col;
    logic [13:0] block_row;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_rgba;
    logic [35:0] byte_address;
    logic        last_texel;
  } out_t;

  typedef logic [3:0][31:0] palette_t;

  // Channel widening tables, c*255/31 and c*255/63
  function automatic logic [31:0][7:0] build_expand5();
    logic [31:0][7:0] t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255) / 31);
    end
    return t;
  endfunction

  function automatic logic [63:0][7:0] build_expand6();
    logic [63:0][7:0] t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * 255) / 63);
    end
    return t;
  endfunction

  localparam logic [31:0][7:0] Expand5 = build_expand5();
  localparam logic [63:0][7:0] Expand6 = build_expand6();

  // (2a+b+1)/3 on channel values of up to six bits
  function automatic logic [5:0] mix_third(logic [5:0] a, logic [5:0] b);
    logic [7:0]  s;
    logic [16:0] p;
    s = {1'b0, a, 1'b0} + {2'b00, b} + 8'd1;
    p = 17'(s) * 17'(DivThreeMul);
    return p[DivThreeShift +: 6];
  endfunction

  // (a+b+1)/2 on channel values of up to six bits
  function automatic logic [5:0] mix_half(logic [5:0] a, logic [5:0] b);
    logic [6:0] s;
    s = {1'b0, a} + {1'b0, b} + 7'd1;
    return s[6:1];
  endfunction

  // RGB565 fields to opaque RGBA8888, red in byte 0
  function automatic logic [31:0] widen(logic [4:0] r, logic [5:0] g, logic [4:0] b);
    return {AlphaOpaque, Expand5[b], Expand6[g], Expand5[r]};
  endfunction

endpackage

// ----- rtl/bc1_palette.sv -----
module bc1_palette (
  input  logic [31:0]        colours_i,
  output bc1_pkg::palette_t  palette_o
);

  logic [15:0] c0, c1;
  logic        four_colour;
  logic [4:0]  r0, r1, b0, b1;
  logic [5:0]  g0, g1;
  logic [4:0]  r2, b2, r3, b3;
  logic [5:0]  g2, g3;

  assign c0 = colours_i[15:0];
  assign c1 = colours_i[31:16];
  assign four_colour = c0 > c1;

  assign r0 = c0[15:11];
  assign g0 = c0[10:5];
  assign b0 = c0[4:0];
  assign r1 = c1[15:11];
  assign g1 = c1[10:5];
  assign b1 = c1[4:0];

  // Middle entries: thirds in four-colour mode; otherwise entry 2 is the midpoint
  always_comb begin
    if (four_colour) begin
      r2 = 5'(bc1_pkg::mix_third({1'b0, r0}, {1'b0, r1}));
      g2 = bc1_pkg::mix_third(g0, g1);
      b2 = 5'(bc1_pkg::mix_third({1'b0, b0}, {1'b0, b1}));
    end else begin
      r2 = 5'(bc1_pkg::mix_half({1'b0, r0}, {1'b0, r1}));
      g2 = bc1_pkg::mix_half(g0, g1);
      b2 = 5'(bc1_pkg::mix_half({1'b0, b0}, {1'b0, b1}));
    end
    r3 = 5'(bc1_pkg::mix_third({1'b0, r1}, {1'b0, r0}));
    g3 = bc1_pkg::mix_third(g1, g0);
    b3 = 5'(bc1_pkg::mix_third({1'b0, b1}, {1'b0, b0}));
  end

  assign palette_o[0] = bc1_pkg::widen(r0, g0, b0);
  assign palette_o[1] = bc1_pkg::widen(r1, g1, b1);
  assign palette_o[2] = bc1_pkg::widen(r2, g2, b2);
  // entry 3 is transparent black in three-colour mode
  assign palette_o[3] = four_colour ? bc1_pkg::widen(r3, g3, b3) : 32'h0;

endmodule

// ----- rtl/bc1_block_decode_top.sv -----
// Path: the first texel of a block goes through the block register, then the output register.
// Throughput: one texel per cycle on the result channel while the output is not stalled; the
// next block is taken in the cycle its predecessor's last texel moves to the output register.
// Reset: asynchronous, active low; clears the configuration registers and all valid
// flags and the texel counter. Payload registers are not reset.
module bc1_block_decode_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bc1_pkg::in_t       in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bc1_pkg::out_t      out_data_o
);

  logic [15:0] width_q, origin_x_q, origin_y_q;

  bc1_pkg::palette_t palette_d, palette_q;
  logic [31:0]       idx_q;
  logic [16:0]       x0_q, y0_q;
  logic              blk_valid_q;
  logic [3:0]        cnt_q;

  logic              out_valid_q;
  bc1_pkg::out_t     out_q, out_d;

  logic              out_ready, emit, blk_done, in_accept;
  logic [16:0]       x_cur, y_cur;
  logic [32:0]       row_prod;
  logic [33:0]       pix_index;
  logic [1:0]        sel;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= '0;
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bc1_pkg::RegRowPitch: width_q    <= cfg_data_i;
        bc1_pkg::RegOriginX:  origin_x_q <= cfg_data_i;
        bc1_pkg::RegOriginY:  origin_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake control
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign emit       = blk_valid_q && out_ready;
  assign blk_done   = emit && (cnt_q == 4'hF);
  assign in_stall_o = blk_valid_q && !blk_done;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Palette built as the block is taken in
  bc1_palette u_palette (
    .colours_i (in_data_i.block_word[31:0]),
    .palette_o (palette_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_valid_q <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        blk_valid_q <= 1'b1;
      end else if (blk_done) begin
        blk_valid_q <= 1'b0;
      end
      // wraps to zero after the sixteenth texel
      if (emit) begin
        cnt_q <= cnt_q + 4'd1;
      end
      if (out_ready) begin
        out_valid_q <= blk_valid_q;
      end
    end
  end

  // Block register: palette, indices and top-left pixel on the canvas
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      palette_q <= palette_d;
      idx_q     <= in_data_i.block_word[63:32];
      x0_q      <= 17'(origin_x_q) + 17'({in_data_i.block_col, 2'b00});
      y0_q      <= 17'(origin_y_q) + 17'({in_data_i.block_row, 2'b00});
    end
  end

  // Texel selection and canvas address
  always_comb begin
    x_cur     = x0_q + 17'(cnt_q[1:0]);
    y_cur     = y0_q + 17'(cnt_q[3:2]);
    row_prod  = 33'(y_cur) * 33'(width_q);
    pix_index = 34'(row_prod) + 34'(x_cur);
    sel       = idx_q[{cnt_q, 1'b0} +: 2];

    out_d.pixel_rgba   = palette_q[sel];
    out_d.byte_address = {pix_index, 2'b00};
    out_d.last_texel   = (cnt_q == 4'hF);
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- tb/bc1_texel_checker.sv -----
module bc1_texel_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_data_i,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  bc1_pkg::in_t   in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  bc1_pkg::out_t  out_data_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o,
  output int unsigned    texel_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the layout registers
  logic [15:0] row_pitch;
  logic [15:0] origin_x;
  logic [15:0] origin_y;

  // Texels still owed by the block, oldest first
  bc1_pkg::out_t texel_q[$];

  // 5/6/5 channel values to RGBA8888 with the alpha byte given
  function automatic logic [31:0] rgba_of(input int unsigned r, input int unsigned g,
                                          input int unsigned b, input logic [7:0] alpha);
    logic [7:0] r8, g8, b8;
    r8 = 8'((r * 255) / 31);
    g8 = 8'((g * 255) / 63);
    b8 = 8'((b * 255) / 31);
    return {alpha, b8, g8, r8};
  endfunction

  // One middle palette entry: two-thirds/one-third blend or plain average
  function automatic logic [31:0] blend_entry(input logic [15:0] ca, input logic [15:0] cb,
                                              input bit thirds);
    int unsigned ra, ga, ba, rb, gb, bb;
    ra = ca[15:11]; ga = ca[10:5]; ba = ca[4:0];
    rb = cb[15:11]; gb = cb[10:5]; bb = cb[4:0];
    if (thirds) begin
      return rgba_of((2 * ra + rb + 1) / 3, (2 * ga + gb + 1) / 3,
                     (2 * ba + bb + 1) / 3, 8'hFF);
    end
    return rgba_of((ra + rb + 1) / 2, (ga + gb + 1) / 2, (ba + bb + 1) / 2, 8'hFF);
  endfunction

  // Expand one block into its sixteen texels and queue them
  function automatic void decode_block_texels(input bc1_pkg::in_t blk);
    logic [15:0]   c0, c1;
    logic [31:0]   palette [4];
    logic [1:0]    sel;
    logic [63:0]   px, py, addr;
    bc1_pkg::out_t texel;
    c0 = blk.block_word[15:0];
    c1 = blk.block_word[31:16];
    palette[0] = rgba_of(c0[15:11], c0[10:5], c0[4:0], 8'hFF);
    palette[1] = rgba_of(c1[15:11], c1[10:5], c1[4:0], 8'hFF);
    if (c0 > c1) begin
      palette[2] = blend_entry(c0, c1, 1'b1);
      palette[3] = blend_entry(c1, c0, 1'b1);
    end else begin
      // three-colour mode: entry 3 is transparent black
      palette[2] = blend_entry(c0, c1, 1'b0);
      palette[3] = 32'h0;
    end
    for (int k = 0; k < 16; k++) begin
      sel  = blk.block_word[32 + 2 * k +: 2];
      px   = 64'(origin_x) + 64'(blk.block_col) * 64'd4 + 64'(k % 4);
      py   = 64'(origin_y) + 64'(blk.block_row) * 64'd4 + 64'(k / 4);
      addr = (py * 64'(row_pitch) + px) * 64'd4;
      texel.pixel_rgba   = palette[sel];
      texel.byte_address = addr[35:0];
      texel.last_texel   = (k == 15);
      texel_q.push_back(texel);
    end
  endfunction

  // Monitor all three ports at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    bc1_pkg::out_t want;
    if (!rst_ni) begin
      row_pitch     = '0;
      origin_x      = '0;
      origin_y      = '0;
      texel_q.delete();
      fail_count_o  = 0;
      texel_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        texel_count_o++;
        if (texel_q.size() == 0) begin
          $error("unexpected texel transfer: rgba %h addr %h last %b",
                 out_data_i.pixel_rgba, out_data_i.byte_address, out_data_i.last_texel);
          fail_count_o++;
        end else begin
          want = texel_q.pop_front();
          if (out_data_i.pixel_rgba !== want.pixel_rgba) begin
            $error("pixel_rgba: expected %h, got %h", want.pixel_rgba, out_data_i.pixel_rgba);
            fail_count_o++;
          end
          if (out_data_i.byte_address !== want.byte_address) begin
            $error("byte_address: expected %h, got %h",
                   want.byte_address, out_data_i.byte_address);
            fail_count_o++;
          end
          if (out_data_i.last_texel !== want.last_texel) begin
            $error("last_texel: expected %b, got %b", want.last_texel, out_data_i.last_texel);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        decode_block_texels(in_data_i);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bc1_pkg::RegRowPitch: row_pitch = cfg_data_i;
          bc1_pkg::RegOriginX:  origin_x  = cfg_data_i;
          bc1_pkg::RegOriginY:  origin_y  = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = texel_q.size();
  end

endmodule

// ----- tb/tb_bc1_block_decode_top.sv -----
module tb_bc1_block_decode_top;

  timeunit 1ns;
  timeprecision 1ps;

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic          cfg_we     = 1'b0;
  logic [1:0]    cfg_idx    = bc1_pkg::RegRowPitch;
  logic [15:0]   cfg_data   = '0;
  logic          in_valid   = 1'b0;
  bc1_pkg::in_t  in_data    = '0;
  logic          in_stall;
  logic          out_valid;
  logic          out_stall  = 1'b0;
  bc1_pkg::out_t out_data;

  int unsigned fail_count;
  int unsigned texels_pending;
  int unsigned texels_checked;

  int unsigned blocks_sent   = 0;
  int unsigned layouts_used  = 0;
  int unsigned burst_left    = 0;

  always #2 clk = ~clk;

  bc1_block_decode_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  bc1_texel_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .fail_count_o  (fail_count),
    .pending_o     (texels_pending),
    .texel_count_o (texels_checked)
  );

  // Receiver back-pressure: the mode (none, light, heavy or periodic stalls) is redrawn at random
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned period;
    forever begin
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(40, 300);
      period = $urandom_range(2, 7);
      for (int unsigned c = 0; c < span; c++) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          2: out_stall = ($urandom_range(0, 3) != 0);
          default: out_stall = ((c % period) == 0);
        endcase
      end
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("[bc1_block_decode_top] ERROR");
    $finish;
  end

  // Write all three layout registers; the block must be idle
  task automatic set_layout(input logic [15:0] width, input logic [15:0] ox,
                            input logic [15:0] oy);
    cfg_we = 1'b1; cfg_idx = bc1_pkg::RegRowPitch; cfg_data = width;
    @(negedge clk);
    cfg_idx = bc1_pkg::RegOriginX; cfg_data = ox;
    @(negedge clk);
    cfg_idx = bc1_pkg::RegOriginY; cfg_data = oy;
    @(negedge clk);
    cfg_we = 1'b0;
    layouts_used++;
  endtask

  // Hold off new blocks until every queued texel has come out
  task automatic wait_for_texels();
    in_valid = 1'b0;
    burst_left = 0;
    while (texels_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Offer one block, opening a new burst after a random gap when needed
  task automatic send_block(input bc1_pkg::in_t blk);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 30)
                                               : $urandom_range(1, 6);
    end
    in_valid = 1'b1;
    in_data  = blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    blocks_sent++;
  endtask

  task automatic send_words(input logic [15:0] c0, input logic [15:0] c1,
                            input logic [31:0] idx, input logic [13:0] col,
                            input logic [13:0] row);
    bc1_pkg::in_t blk;
    blk.block_word = {idx, c1, c0};
    blk.block_col  = col;
    blk.block_row  = row;
    send_block(blk);
  endtask

  // Random block: mostly free content, biased towards the mode boundaries
  function automatic bc1_pkg::in_t random_block();
    bc1_pkg::in_t blk;
    logic [15:0]  ca, cb;
    int unsigned  pick;
    pick = $urandom_range(0, 99);
    blk.block_word = {$urandom(), $urandom()};
    ca = blk.block_word[15:0];
    cb = blk.block_word[31:16];
    if (pick < 15) begin
      // equal end colours
      blk.block_word[31:16] = ca;
    end else if (pick < 35) begin
      // force three-colour ordering
      if (ca > cb) blk.block_word[31:0] = {ca, cb};
    end else if (pick < 45) begin
      // saturated end colours
      for (int i = 0; i < 2; i++) begin
        case ($urandom_range(0, 5))
          0: blk.block_word[16 * i +: 16] = 16'h0000;
          1: blk.block_word[16 * i +: 16] = 16'hFFFF;
          2: blk.block_word[16 * i +: 16] = 16'hF800;
          3: blk.block_word[16 * i +: 16] = 16'h07E0;
          4: blk.block_word[16 * i +: 16] = 16'h001F;
          default: blk.block_word[16 * i +: 16] = 16'h0001;
        endcase
      end
    end
    blk.block_col = ($urandom_range(0, 4) == 0) ?
                    ($urandom_range(0, 1) ? 14'h3FFF : 14'h0000) :
                    14'($urandom_range(0, 16383));
    blk.block_row = ($urandom_range(0, 4) == 0) ?
                    ($urandom_range(0, 1) ? 14'h3FFF : 14'h0000) :
                    14'($urandom_range(0, 16383));
    return blk;
  endfunction

  task automatic send_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_block(random_block());
    end
  endtask

  // Stimulus
  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed blocks on a small canvas
    set_layout(16'd16, 16'd0, 16'd0);
    send_words(16'hFFFF, 16'h0000, 32'hE4E4_E4E4, 14'd0,     14'd0);
    send_words(16'h0000, 16'hFFFF, 32'hE4E4_E4E4, 14'd1,     14'd0);
    send_words(16'h8410, 16'h8410, 32'hFFFF_FFFF, 14'd0,     14'd1);
    send_words(16'h0000, 16'h0000, 32'h0000_0000, 14'd2,     14'd2);
    send_words(16'hF800, 16'h07E0, 32'h1B1B_1B1B, 14'd3,     14'd1);
    send_words(16'h07E0, 16'hF800, 32'h1B1B_1B1B, 14'd3,     14'd2);
    send_words(16'h001F, 16'h0000, 32'hAAAA_AAAA, 14'd0,     14'd3);
    send_words(16'h0001, 16'h0000, 32'hFFFF_FFFF, 14'd1,     14'd1);
    send_words(16'h0000, 16'h0001, 32'hFFFF_FFFF, 14'd1,     14'd2);
    send_words(16'h5555, 16'hAAAA, 32'h5555_5555, 14'd2,     14'd0);
    send_words(16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 14'd2,     14'd1);
    send_words(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 14'h3FFF,  14'h3FFF);
    send_words(16'h0000, 16'h0000, 32'h0000_0000, 14'h3FFF,  14'd0);
    send_words(16'h7BEF, 16'h0841, 32'h1234_5678, 14'd0,     14'h3FFF);
    send_words(16'hFFFE, 16'hFFFF, 32'h9C9C_3636, 14'd5,     14'd7);
    send_words(16'hFFFF, 16'hFFFE, 32'h9C9C_3636, 14'd6,     14'd7);
    wait_for_texels();

    // Largest canvas and origin: addresses near the top of the range
    set_layout(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_random(75);
    wait_for_texels();

    // Zero width: every row collapses onto row zero
    set_layout(16'd0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    send_random(75);
    wait_for_texels();

    // Single-pixel pitch with opposite origin extremes
    set_layout(16'd1, 16'hFFFF, 16'd0);
    send_random(60);
    wait_for_texels();

    // Random layouts, one with a full drain part way through
    for (int p = 0; p < 3; p++) begin
      set_layout(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
      send_random(40);
      if (p == 1) wait_for_texels();
      send_random(50);
      wait_for_texels();
    end

    repeat (20) @(negedge clk);
    $display("Run covered %0d blocks and %0d texels over %0d canvas layouts,",
             blocks_sent, texels_checked, layouts_used);
    $display("including zero and full width, both palette modes and extreme block positions.");
    if (fail_count == 0) begin
      $display("[bc1_block_decode_top] OK");
    end else begin
      $display("[bc1_block_decode_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bc1_pkg.sv
rtl/bc1_palette.sv
rtl/bc1_block_decode_top.sv
tb/bc1_texel_checker.sv
tb/tb_bc1_block_decode_top.sv
